// ===== hdl/half_step_stepper_driver_top_assert.svh =====
// assertion macros for the half-step stepper driver
// no dependencies; included by modules that carry assertions
`ifndef HALF_STEP_STEPPER_DRIVER_TOP_ASSERT_SVH
`define HALF_STEP_STEPPER_DRIVER_TOP_ASSERT_SVH

`ifndef SYNTH
// checked property, disabled while reset is active
`define HSSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define HSSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSSD_ASSERT(label, prop, msg)
`define HSSD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/hssd_pkg.sv =====
// types, codes and coil table for the half-step stepper driver
// no dependencies
`timescale 1ns / 1ps

package hssd_pkg;

    // phases of the half-step sequence
    localparam int PHASES  = 8;
    localparam int PHASE_W = $clog2(PHASES);

    // request type codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_OFF  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY    = 1'd1;

    // configuration reset values
    localparam logic [15:0] STEPS_PER_REV_RST = 16'd1024;
    localparam logic [15:0] STEP_DELAY_RST    = 16'd58;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] move_steps;
    } in_t;

    typedef struct packed {
        logic [3:0]  coils;
        logic        stepped;
        logic [15:0] position;
        logic [15:0] steps_remaining;
        logic        busy_res;
    } out_t;

    // request held in the input register
    typedef struct packed {
        logic valid;
        in_t  req;
    } stage_t;

    // coil pattern for one phase, bits 3..0
    function automatic logic [3:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'b1100;
            3'd1:    pat = 4'b1000;
            3'd2:    pat = 4'b1010;
            3'd3:    pat = 4'b0010;
            3'd4:    pat = 4'b0011;
            3'd5:    pat = 4'b0001;
            3'd6:    pat = 4'b0101;
            default: pat = 4'b0100;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/half_step_stepper_driver_top.sv =====
// half-step stepper driver: a request is held in the input register, its result
// in the result register; one request per cycle while results are taken; the
// state update is one pass between the input register and the result register
// reset (rst_n low, asynchronous) clears position, count, direction, elapsed
// time and coils, and loads steps per revolution 1024 and step delay 58 ms
// depends on hssd_pkg, hssd_req_stage, hssd_step_core, hssd_out_stage
`timescale 1ns / 1ps

module half_step_stepper_driver_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           request_valid,
    output logic                           request_ready,
    input  hssd_pkg::in_t                  request,
    output logic                           result_valid,
    input  logic                           result_ready,
    output hssd_pkg::out_t                 result,
    input  logic                           cfg_we,
    input  logic [hssd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import hssd_pkg::*;

    stage_t stage;
    out_t   res;
    logic   advance;

    // input register
    hssd_req_stage u_req_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .advance       (advance),
        .stage         (stage)
    );

    // motor state and step logic
    hssd_step_core u_step_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stage     (stage),
        .advance   (advance),
        .res       (res)
    );

    // result register
    hssd_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .res          (res),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== hdl/hssd_req_stage.sv =====
// input register stage: holds one accepted request
// depends on hssd_pkg
`timescale 1ns / 1ps

module hssd_req_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    output logic           request_ready,
    input  hssd_pkg::in_t  request,
    input  logic           advance,
    output hssd_pkg::stage_t stage
);
    import hssd_pkg::*;

    logic valid_reg;
    logic valid_next;
    in_t  req_reg;
    logic take;

    // accept a new request when the stage is empty or moving on
    assign request_ready = !valid_reg || advance;
    assign take          = request_valid && request_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (request_ready)
        begin
            valid_next = request_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= request;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.req   = req_reg;

endmodule

// ===== hdl/hssd_step_core.sv =====
// motor state, configuration registers and step logic
// depends on hssd_pkg and half_step_stepper_driver_top_assert.svh
`timescale 1ns / 1ps

module hssd_step_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data,
    input  hssd_pkg::stage_t                 stage,
    input  logic                             advance,
    output hssd_pkg::out_t                   res
);
    import hssd_pkg::*;
    `include "half_step_stepper_driver_top_assert.svh"

    logic [15:0] spr_reg,      spr_next;
    logic [15:0] delay_reg,    delay_next;
    logic [15:0] position_reg, position_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        forward_reg,  forward_next;
    logic [15:0] elapsed_reg,  elapsed_next;
    logic [3:0]  coil_reg,     coil_next;

    logic        fire;
    logic        is_tick;
    logic        is_move;
    logic        is_off;
    logic [15:0] raw;
    logic [15:0] el_sel;
    logic [15:0] rem_sel;
    logic        fwd_sel;
    logic [15:0] last_pos;
    logic [15:0] step_pos;
    logic        do_step;

    assign fire    = stage.valid && advance;
    assign raw     = stage.req.move_steps;
    assign is_tick = (stage.req.req_type == REQ_TICK);
    assign is_move = (stage.req.req_type == REQ_MOVE);
    assign is_off  = (stage.req.req_type == REQ_OFF);

    // configuration write decode
    always_comb
    begin
        spr_next   = spr_reg;
        delay_next = delay_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEPS_PER_REV: spr_next   = cfg_data;
                CFG_STEP_DELAY:    delay_next = cfg_data;
                default:           ;
            endcase
        end
    end

    // elapsed count after a tick, saturating
    assign el_sel = (is_tick && elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;

    // move command loads the magnitude and the direction
    always_comb
    begin
        rem_sel = remaining_reg;
        fwd_sel = forward_reg;
        if (is_move)
        begin
            rem_sel = raw[15] ? (~raw + 16'd1) : raw;
            if (raw != 16'd0)
            begin
                fwd_sel = !raw[15];
            end
        end
    end

    // step decision and next position, zero span wraps at 65536
    assign do_step  = (is_tick || is_move) && (rem_sel != 16'd0) && (el_sel >= delay_reg);
    assign last_pos = spr_reg - 16'd1;

    always_comb
    begin
        if (fwd_sel)
        begin
            step_pos = (position_reg >= last_pos) ? 16'd0 : position_reg + 16'd1;
        end
        else
        begin
            step_pos = (position_reg == 16'd0) ? last_pos : position_reg - 16'd1;
        end
    end

    // state update for the request in the input register
    always_comb
    begin
        position_next  = position_reg;
        remaining_next = rem_sel;
        forward_next   = fwd_sel;
        elapsed_next   = el_sel;
        coil_next      = coil_reg;
        if (do_step)
        begin
            position_next  = step_pos;
            remaining_next = rem_sel - 16'd1;
            elapsed_next   = 16'd0;
            coil_next      = coil_pattern(step_pos[PHASE_W-1:0]);
        end
        else if (is_off)
        begin
            coil_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg       <= STEPS_PER_REV_RST;
            delay_reg     <= STEP_DELAY_RST;
            position_reg  <= 16'd0;
            remaining_reg <= 16'd0;
            forward_reg   <= 1'b0;
            elapsed_reg   <= 16'd0;
            coil_reg      <= 4'd0;
        end
        else
        begin
            spr_reg   <= spr_next;
            delay_reg <= delay_next;
            if (fire)
            begin
                position_reg  <= position_next;
                remaining_reg <= remaining_next;
                forward_reg   <= forward_next;
                elapsed_reg   <= elapsed_next;
                coil_reg      <= coil_next;
            end
        end
    end

    // result reflects the state after this request
    assign res.coils           = coil_next;
    assign res.stepped         = do_step;
    assign res.position        = position_next;
    assign res.steps_remaining = remaining_next;
    assign res.busy_res        = (remaining_next != 16'd0);

    // checks
    `HSSD_ASSERT(a_step_clears_elapsed, (fire && do_step) |=> (elapsed_reg == 16'd0),
                 "step did not clear elapsed count")
    `HSSD_ASSERT(a_step_drives_coils, (fire && do_step) |=> (coil_reg != 4'd0),
                 "step left coils off")
    `HSSD_ASSERT(a_step_counts_down,
                 (fire && do_step) |=> (remaining_reg == $past(rem_sel) - 16'd1),
                 "remaining count not decremented")
    `HSSD_ASSERT(a_remaining_bound, remaining_reg <= 16'h8000, "remaining count out of range")

endmodule

// ===== hdl/hssd_out_stage.sv =====
// result register stage toward the consumer
// depends on hssd_pkg
`timescale 1ns / 1ps

module hssd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  hssd_pkg::stage_t stage,
    input  hssd_pkg::out_t   res,
    output logic             advance,
    output logic             result_valid,
    input  logic             result_ready,
    output hssd_pkg::out_t   result
);
    import hssd_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t result_reg;

    // the pipeline moves when the result register is free or being taken
    assign advance = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = stage.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (advance && stage.valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the half-step stepper driver top level
// depends on hssd_pkg and half_step_stepper_driver_top; reads no files
`timescale 1ns / 1ps

module tb_top;
    import hssd_pkg::*;

    // request code that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 244;
    localparam int ERR_SHOWN   = 10;

    // coil patterns, phase 0 in the low nibble
    localparam logic [31:0] COIL_SEQ = {4'b0100, 4'b0101, 4'b0001, 4'b0011,
                                        4'b0010, 4'b1010, 4'b1000, 4'b1100};

    typedef enum logic [1:0] {ROW_REQ, ROW_SET_REV, ROW_SET_DELAY} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [1:0]  req_type;
        logic [15:0] move_steps;
        logic [15:0] cfg_val;
        logic        has_lit;
        out_t        lit;
    } dir_row_t;

    localparam out_t NO_LIT = '0;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 request_valid;
    logic                 request_ready;
    in_t                  request;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    out_t                 result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // shadow of the motor state and configuration
    logic [15:0] cfg_rev;
    logic [15:0] cfg_delay;
    logic [15:0] mtr_pos;
    logic [15:0] mtr_left;
    logic [15:0] mtr_elapsed;
    logic        mtr_fwd;
    logic [3:0]  mtr_coils;

    out_t status_fifo[$];
    int   err_count = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    // directed rows: reset state, field extremes, special cases
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_REQ, REQ_OFF,    16'h0000, 16'd0, 1'b1, '{4'h0, 1'b0, 16'd0, 16'd0, 1'b0}},
        '{ROW_REQ, REQ_UNUSED, 16'h7FFF, 16'd0, 1'b1, '{4'h0, 1'b0, 16'd0, 16'd0, 1'b0}},
        '{ROW_REQ, REQ_TICK,   16'hFFFF, 16'd0, 1'b1, '{4'h0, 1'b0, 16'd0, 16'd0, 1'b0}},
        '{ROW_REQ, REQ_MOVE,   16'h7FFF, 16'd0, 1'b1, '{4'h0, 1'b0, 16'd0, 16'd32767, 1'b1}},
        '{ROW_REQ, REQ_MOVE,   16'h8000, 16'd0, 1'b1, '{4'h0, 1'b0, 16'd0, 16'd32768, 1'b1}},
        '{ROW_REQ, REQ_MOVE,   16'h0000, 16'd0, 1'b1, '{4'h0, 1'b0, 16'd0, 16'd0, 1'b0}},
        '{ROW_SET_DELAY, REQ_TICK, 16'h0000, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'h0003, 16'd0, 1'b1, '{4'b1000, 1'b1, 16'd1, 16'd2, 1'b1}},
        '{ROW_REQ, REQ_TICK,   16'h0000, 16'd0, 1'b1, '{4'b1010, 1'b1, 16'd2, 16'd1, 1'b1}},
        '{ROW_REQ, REQ_OFF,    16'h0000, 16'd0, 1'b1, '{4'b0000, 1'b0, 16'd2, 16'd1, 1'b1}},
        '{ROW_REQ, REQ_TICK,   16'h0000, 16'd0, 1'b1, '{4'b0010, 1'b1, 16'd3, 16'd0, 1'b0}},
        '{ROW_REQ, REQ_MOVE,   16'hFFFF, 16'd0, 1'b1, '{4'b1010, 1'b1, 16'd2, 16'd0, 1'b0}},
        '{ROW_REQ, REQ_MOVE,   16'h0000, 16'd0, 1'b1, '{4'b1010, 1'b0, 16'd2, 16'd0, 1'b0}},
        '{ROW_SET_REV, REQ_TICK, 16'h0000, 16'd2, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'h0001, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'hFFFF, 16'd0, 1'b0, NO_LIT},
        '{ROW_SET_REV, REQ_TICK, 16'h0000, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'hFFFE, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_TICK,   16'h0000, 16'd0, 1'b0, NO_LIT},
        '{ROW_SET_REV, REQ_TICK, 16'h0000, 16'd65535, 1'b0, NO_LIT},
        '{ROW_SET_DELAY, REQ_TICK, 16'h0000, 16'd65535, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'h0001, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'h5A5A, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_MOVE,   16'hA5A5, 16'd0, 1'b0, NO_LIT},
        '{ROW_REQ, REQ_TICK,   16'h0000, 16'd0, 1'b0, NO_LIT}
    };

    half_step_stepper_driver_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // one step if steps remain and the delay has run out
    function automatic logic try_advance();
        logic [16:0] span;
        logic [16:0] nxt;
        if (mtr_left == 16'd0 || mtr_elapsed < cfg_delay)
            return 1'b0;
        span = (cfg_rev == 16'd0) ? 17'h10000 : {1'b0, cfg_rev};
        if (mtr_fwd)
        begin
            nxt = {1'b0, mtr_pos} + 17'd1;
            mtr_pos = (nxt >= span) ? 16'd0 : nxt[15:0];
        end
        else
        begin
            nxt = span - 17'd1;
            mtr_pos = (mtr_pos == 16'd0) ? nxt[15:0] : mtr_pos - 16'd1;
        end
        mtr_left = mtr_left - 16'd1;
        mtr_elapsed = 16'd0;
        mtr_coils = COIL_SEQ[{mtr_pos[2:0], 2'b00} +: 4];
        return 1'b1;
    endfunction

    // motor status after one request
    function automatic out_t next_motor_status(input in_t r);
        out_t        s;
        logic        moved;
        logic [15:0] raw;
        moved = 1'b0;
        raw = r.move_steps;
        case (r.req_type)
            REQ_TICK:
            begin
                if (mtr_elapsed != 16'hFFFF)
                    mtr_elapsed = mtr_elapsed + 16'd1;
                moved = try_advance();
            end
            REQ_MOVE:
            begin
                if (raw == 16'd0)
                    mtr_left = 16'd0;
                else if (raw[15])
                begin
                    mtr_fwd = 1'b0;
                    mtr_left = ~raw + 16'd1;
                end
                else
                begin
                    mtr_fwd = 1'b1;
                    mtr_left = raw;
                end
                moved = try_advance();
            end
            REQ_OFF: mtr_coils = 4'd0;
            default: ;
        endcase
        s.coils = mtr_coils;
        s.stepped = moved;
        s.position = mtr_pos;
        s.steps_remaining = mtr_left;
        s.busy_res = (mtr_left != 16'd0);
        return s;
    endfunction

    // present one request, record its status once accepted
    task automatic send_req(input in_t r, input logic has_lit, input out_t lit);
        out_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_valid = 1'b0;
            @(negedge clk);
        end
        request_valid = 1'b1;
        request = r;
        do
            @(posedge clk);
        while (!request_ready);
        s = next_motor_status(r);
        status_fifo.push_back(has_lit ? lit : s);
        @(negedge clk);
    endtask

    // hold off requests until every status has come back
    task automatic wait_drain();
        request_valid = 1'b0;
        while (status_fifo.size() != 0)
            @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_STEPS_PER_REV)
            cfg_rev = val;
        else
            cfg_delay = val;
    endtask

    // receiver back-pressure
    always @(negedge clk)
        result_ready = ($urandom_range(99) >= recv_stall_pct);

    // status check against the oldest pending one
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (status_fifo.size() == 0)
            begin
                err_count++;
                if (err_count <= ERR_SHOWN)
                    $display("unexpected status: coils %b position %0d", result.coils,
                             result.position);
            end
            else
            begin
                want = status_fifo.pop_front();
                if (result.coils !== want.coils || result.stepped !== want.stepped ||
                    result.position !== want.position ||
                    result.steps_remaining !== want.steps_remaining ||
                    result.busy_res !== want.busy_res)
                begin
                    err_count++;
                    if (err_count <= ERR_SHOWN)
                    begin
                        $display("status mismatch: expected coils %b stepped %b pos %0d",
                                 want.coils, want.stepped, want.position,
                                 " left %0d busy %b", want.steps_remaining, want.busy_res);
                        $display("                 got coils %b stepped %b pos %0d",
                                 result.coils, result.stepped, result.position,
                                 " left %0d busy %b", result.steps_remaining,
                                 result.busy_res);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((request_valid && request_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        in_t         item;
        int          pick;
        int          mag;
        logic [15:0] rev_val;
        logic [15:0] delay_val;

        rst_n = 1'b0;
        request_valid = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = 16'd0;
        cfg_rev = STEPS_PER_REV_RST;
        cfg_delay = STEP_DELAY_RST;
        mtr_pos = 16'd0;
        mtr_left = 16'd0;
        mtr_elapsed = 16'd0;
        mtr_fwd = 1'b0;
        mtr_coils = 4'd0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (dir_table[i])
        begin
            case (dir_table[i].kind)
                ROW_SET_REV:   set_reg(CFG_STEPS_PER_REV, dir_table[i].cfg_val);
                ROW_SET_DELAY: set_reg(CFG_STEP_DELAY, dir_table[i].cfg_val);
                default:
                begin
                    item.req_type = dir_table[i].req_type;
                    item.move_steps = dir_table[i].move_steps;
                    send_req(item, dir_table[i].has_lit, dir_table[i].lit);
                end
            endcase
        end

        // random phases, each with its own settings and idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    rev_val = 16'd1;
                    delay_val = 16'd0;
                end
                1:
                begin
                    rev_val = 16'd0;
                    delay_val = 16'd1;
                end
                2:
                begin
                    rev_val = 16'd65535;
                    delay_val = 16'd2;
                end
                default:
                begin
                    case ($urandom_range(3))
                        0:       rev_val = 16'd8;
                        1:       rev_val = 16'd1024;
                        2:       rev_val = 16'($urandom_range(1, 20));
                        default: rev_val = 16'($urandom);
                    endcase
                    delay_val = ($urandom_range(4) == 0) ? 16'd58 : 16'($urandom_range(0, 6));
                end
            endcase
            set_reg(CFG_STEPS_PER_REV, rev_val);
            set_reg(CFG_STEP_DELAY, delay_val);

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender pause until the pipe is empty
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_drain();
                pick = $urandom_range(99);
                item.move_steps = 16'($urandom);
                if (pick < 55)
                    item.req_type = REQ_TICK;
                else if (pick < 85)
                begin
                    item.req_type = REQ_MOVE;
                    pick = $urandom_range(9);
                    if (pick < 7)
                    begin
                        mag = $urandom_range(1, 24);
                        item.move_steps = $urandom_range(1) ? 16'(-mag) : 16'(mag);
                    end
                    else if (pick == 7)
                        item.move_steps = 16'd0;
                end
                else if (pick < 95)
                    item.req_type = REQ_OFF;
                else
                    item.req_type = REQ_UNUSED;
                send_req(item, 1'b0, NO_LIT);
            end
        end

        // wind down
        wait_drain();
        repeat (8) @(negedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
